>>> rtl/vtdi_pkg.sv
// ----------------------------------------------------------------------------
// vtdi_pkg
// Shared constants, types and helpers of the vertex tuple dedup indexer.
// ----------------------------------------------------------------------------
package vtdi_pkg;

	// Sizing
	localparam int TABLE_DEPTH  = 1024;
	localparam int INDEX_BITS   = 16;
	localparam int ELEMENT_BITS = 16;

	localparam int ADDR_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
	localparam int TUPLE_W = 4 * INDEX_BITS;

	// Port field widths
	localparam int FIELD_W = 16;
	localparam int VIDX_W  = 10;
	localparam int EPOS_W  = 16;
	localparam int CODE_W  = 2;

	// Outcome codes
	localparam logic [CODE_W-1:0] OUT_FOUND = 2'd0;
	localparam logic [CODE_W-1:0] OUT_ADDED = 2'd1;
	localparam logic [CODE_W-1:0] OUT_FULL  = 2'd2;
	localparam logic [CODE_W-1:0] OUT_SAT   = 2'd3;

	// Result of one corner
	typedef struct packed {
		logic [VIDX_W-1:0] vertex_index;
		logic [EPOS_W-1:0] element_position;
		logic [CODE_W-1:0] outcome;
	} result_t;

	// Truncate a count to the port field widths
	function automatic logic [VIDX_W-1:0] to_vidx(input logic [31:0] v);
		return v[VIDX_W-1:0];
	endfunction

	function automatic logic [EPOS_W-1:0] to_epos(input logic [31:0] v);
		return v[EPOS_W-1:0];
	endfunction

endpackage

>>> rtl/vtdi_ram.sv
// ----------------------------------------------------------------------------
// vtdi_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module vtdi_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/vtdi_ctrl.sv
// ----------------------------------------------------------------------------
// vtdi_ctrl
// Search sequencer: holds the counts, scans the tuple RAM one entry per
// cycle, appends on a miss and builds the result of each corner.
// ----------------------------------------------------------------------------
module vtdi_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	// corner input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_restart,
	input  logic [vtdi_pkg::TUPLE_W-1:0]  in_key,
	// tuple RAM
	output logic                          mem_rd_en,
	output logic [vtdi_pkg::ADDR_W-1:0]   mem_rd_addr,
	input  logic [vtdi_pkg::TUPLE_W-1:0]  mem_rd_data,
	output logic                          mem_wr_en,
	output logic [vtdi_pkg::ADDR_W-1:0]   mem_wr_addr,
	output logic [vtdi_pkg::TUPLE_W-1:0]  mem_wr_data,
	// result
	output logic                          res_valid,
	input  logic                          res_ready,
	output vtdi_pkg::result_t             res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                         state_q;
	logic [vtdi_pkg::TUPLE_W-1:0]       key_q;
	logic [vtdi_pkg::CNT_W-1:0]         entry_cnt_q;
	logic [vtdi_pkg::ELEMENT_BITS-1:0]  elem_cnt_q;
	logic [vtdi_pkg::CNT_W-1:0]         ptr_q;
	logic                               cmp_valid_s1;
	logic [vtdi_pkg::ADDR_W-1:0]        cmp_addr_s1;
	vtdi_pkg::result_t                  res_q;

	logic scanning, saturated, hit, exhausted, full;

	// scan conditions
	assign scanning  = (state_q == ST_SCAN);
	assign saturated = (elem_cnt_q == {vtdi_pkg::ELEMENT_BITS{1'b1}});
	assign hit       = cmp_valid_s1 && (mem_rd_data == key_q);
	assign exhausted = !cmp_valid_s1 && (ptr_q == entry_cnt_q);
	assign full      = (entry_cnt_q == vtdi_pkg::CNT_W'(vtdi_pkg::TABLE_DEPTH));

	// read issue: one entry per cycle below the fill count
	assign mem_rd_en   = scanning && !saturated && (ptr_q < entry_cnt_q);
	assign mem_rd_addr = ptr_q[vtdi_pkg::ADDR_W-1:0];

	// append on a miss with room left
	assign mem_wr_en   = scanning && !saturated && !hit && exhausted && !full;
	assign mem_wr_addr = entry_cnt_q[vtdi_pkg::ADDR_W-1:0];
	assign mem_wr_data = key_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_EMIT);
	assign res       = res_q;

	// key and result payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_q <= in_key;
		end
		cmp_addr_s1 <= mem_rd_addr;
		if (scanning) begin
			if (saturated) begin
				res_q.vertex_index     <= '0;
				res_q.element_position <= vtdi_pkg::to_epos(32'(elem_cnt_q));
				res_q.outcome          <= vtdi_pkg::OUT_SAT;
			end else if (hit) begin
				res_q.vertex_index     <= vtdi_pkg::to_vidx(32'(cmp_addr_s1));
				res_q.element_position <= vtdi_pkg::to_epos(32'(elem_cnt_q));
				res_q.outcome          <= vtdi_pkg::OUT_FOUND;
			end else if (exhausted && full) begin
				res_q.vertex_index     <= '0;
				res_q.element_position <= vtdi_pkg::to_epos(32'(elem_cnt_q));
				res_q.outcome          <= vtdi_pkg::OUT_FULL;
			end else if (exhausted) begin
				res_q.vertex_index     <= vtdi_pkg::to_vidx(32'(entry_cnt_q));
				res_q.element_position <= vtdi_pkg::to_epos(32'(elem_cnt_q));
				res_q.outcome          <= vtdi_pkg::OUT_ADDED;
			end
		end
	end

	// sequencer, counts and scan pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			entry_cnt_q  <= '0;
			elem_cnt_q   <= '0;
			ptr_q        <= '0;
			cmp_valid_s1 <= 1'b0;
		end else begin
			// no read is issued outside the scan, so this is low in idle
			cmp_valid_s1 <= mem_rd_en;
			if (mem_rd_en) begin
				ptr_q <= ptr_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						ptr_q   <= '0;
						state_q <= ST_SCAN;
						if (in_restart) begin
							entry_cnt_q <= '0;
							elem_cnt_q  <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (saturated) begin
						state_q <= ST_EMIT;
					end else if (hit) begin
						elem_cnt_q <= elem_cnt_q + 1'b1;
						state_q    <= ST_EMIT;
					end else if (exhausted) begin
						if (!full) begin
							entry_cnt_q <= entry_cnt_q + 1'b1;
							elem_cnt_q  <= elem_cnt_q + 1'b1;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/vertex_tuple_dedup_indexer.sv
// ----------------------------------------------------------------------------
// vertex_tuple_dedup_indexer
// Deduplicates mesh corner tuples against a RAM of unique tuples and hands
// back a vertex index and an element slot for every corner.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                  | tuser
//  s_axis   | in  | position, texcoord, normal, color idx  | restart
//  m_axis   | out | vertex_index, element_position         | outcome
//
//  A corner's scan time grows with entry_count, up to TABLE_DEPTH entries:
//  the single read port of the tuple RAM checks one stored entry per cycle.
//  A saturated element count ends the scan without reading the tuple RAM.
//  Reset clears both counts at once; the tuple RAM needs no clearing.
//  The output register holds a result while m_axis stalls, and the next
//  corner is taken meanwhile; its result waits until the register frees.
// ----------------------------------------------------------------------------
module vertex_tuple_dedup_indexer (
	input  logic        clk,
	input  logic        arst_n,
	// corner input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // position[15:0], texcoord, normal, color
	input  logic [0:0]  s_axis_tuser,  // restart
	// result output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // vertex_index[9:0], element_position, zero pad
	output logic [1:0]  m_axis_tuser   // outcome
);

	logic [vtdi_pkg::TUPLE_W-1:0] key;
	logic                         mem_rd_en, mem_wr_en;
	logic [vtdi_pkg::ADDR_W-1:0]  mem_rd_addr, mem_wr_addr;
	logic [vtdi_pkg::TUPLE_W-1:0] mem_rd_data, mem_wr_data;
	logic                         res_valid, res_ready;
	vtdi_pkg::result_t            res;
	logic                         out_valid_q;
	vtdi_pkg::result_t            out_q;

	// keep the low index bits of each field
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			key[k*vtdi_pkg::INDEX_BITS +: vtdi_pkg::INDEX_BITS] =
				s_axis_tdata[k*vtdi_pkg::FIELD_W +: vtdi_pkg::INDEX_BITS];
		end
	end

	vtdi_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_restart  (s_axis_tuser[0]),
		.in_key      (key),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	vtdi_ram #(
		.WIDTH (vtdi_pkg::TUPLE_W),
		.DEPTH (vtdi_pkg::TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// output register
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_q.element_position, out_q.vertex_index};
	assign m_axis_tuser  = out_q.outcome;

endmodule
